// File: hw/rtl/rdf_pkg.sv
// rdf_pkg: shared types, codes and defaults for the record deque with filter
`timescale 1ns / 1ps

package rdf_pkg;

   localparam int RDF_DEPTH = 16;
   localparam int FIELD_W   = 16;
   localparam int OCC_W     = 5;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_FILTER     = 2'd3
   } rdf_cmd_code_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_NOMATCH = 2'd3
   } rdf_status_code_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [FIELD_W-1:0] title_handle;
      logic [FIELD_W-1:0] page_count;
      logic [FIELD_W-1:0] page_limit;
   } rdf_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] out_title;
      logic [FIELD_W-1:0] out_pages;
      logic               last_of_run;
      logic [OCC_W-1:0]   occupancy;
   } rdf_rsp_type;

   typedef struct packed {
      logic [FIELD_W-1:0] title;
      logic [FIELD_W-1:0] pages;
   } rdf_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP,
      ST_COUNT,
      ST_COUNT_END,
      ST_EMIT,
      ST_FINISH
   } rdf_state_type;

   typedef enum logic [2:0] {
      RSP_PUSH_OK,
      RSP_FULL,
      RSP_EMPTY,
      RSP_POP,
      RSP_NOMATCH,
      RSP_MATCH
   } rdf_rsp_sel_type;

   // controller to datapath
   typedef struct packed {
      logic            capture;
      logic            push_front;
      logic            push_back;
      logic            rd_front;
      logic            pop_commit;
      logic            walk_restart;
      logic            count_step;
      logic            emit_step;
      logic            commit_filter;
      logic            load_rsp;
      rdf_rsp_sel_type rsp_sel;
   } rdf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] command;
      logic       full;
      logic       empty;
      logic       match;
      logic       walk_last;
      logic       hits_zero;
   } rdf_stat_type;

endpackage

// File: hw/rtl/rdf_datapath.sv
// rdf_datapath: record ring memory, pointers, filter walk counters and result register
`timescale 1ns / 1ps

module rdf_datapath
   import rdf_pkg::*;
#(
   parameter int DEPTH = RDF_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  rdf_req_type  req_payload,
   input  rdf_cmd_type  cmd,
   output rdf_stat_type stat,
   output rdf_rsp_type  rsp_payload
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rdf_entry_type mem [DEPTH];

   logic [PW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic [CW-1:0] hits_ff, hits_in;
   logic [CW-1:0] emitted_ff, emitted_in;
   rdf_req_type   req_ff, req_in;
   rdf_entry_type rd_data_ff;
   rdf_rsp_type   rsp_ff, rsp_in;

   logic [PW-1:0] rd_addr;
   logic [PW-1:0] wr_addr;
   logic          wr_en;
   rdf_entry_type wr_data;
   logic          match;
   logic [CW-1:0] occ_val;

   function automatic logic [PW-1:0] ring_slot(input logic [PW-1:0] base,
                                               input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   assign match = rd_data_ff.pages >= req_ff.page_limit;

   always_comb begin
      front_in   = front_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      kept_in    = kept_ff;
      hits_in    = hits_ff;
      emitted_in = emitted_ff;
      req_in     = req_ff;
      wr_en      = 1'b0;
      wr_addr    = ring_slot(front_ff, kept_ff);
      wr_data    = rd_data_ff;

      if (cmd.capture) begin
         req_in  = req_payload;
         idx_in  = '0;
         hits_in = '0;
      end
      if (cmd.push_front) begin
         front_in = (front_ff == '0) ? PW'(DEPTH - 1) : front_ff - 1'b1;
         wr_en    = 1'b1;
         wr_addr  = front_in;
         wr_data  = '{title: req_ff.title_handle, pages: req_ff.page_count};
         count_in = count_ff + 1'b1;
      end
      if (cmd.push_back) begin
         wr_en    = 1'b1;
         wr_addr  = ring_slot(front_ff, count_ff);
         wr_data  = '{title: req_ff.title_handle, pages: req_ff.page_count};
         count_in = count_ff + 1'b1;
      end
      if (cmd.pop_commit) begin
         front_in = (front_ff == PW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (cmd.walk_restart) begin
         idx_in     = '0;
         kept_in    = '0;
         emitted_in = '0;
      end
      if (cmd.count_step) begin
         idx_in = idx_ff + 1'b1;
         if (match) begin
            hits_in = hits_ff + 1'b1;
         end
      end
      if (cmd.emit_step) begin
         idx_in = idx_ff + 1'b1;
         if (match) begin
            emitted_in = emitted_ff + 1'b1;
         end else begin
            // compaction: kept slot never runs ahead of the read slot
            wr_en   = 1'b1;
            kept_in = kept_ff + 1'b1;
         end
      end
      if (cmd.commit_filter) begin
         count_in = kept_ff;
      end
   end

   // read runs every cycle from the next walk index, so that entry is registered and ready in the following cycle
   assign rd_addr = cmd.rd_front ? front_ff : ring_slot(front_ff, idx_in);

   always_comb begin
      rsp_in  = rsp_ff;
      occ_val = count_ff;
      if (cmd.load_rsp) begin
         rsp_in.status      = STATUS_OK;
         rsp_in.out_title   = '0;
         rsp_in.out_pages   = '0;
         rsp_in.last_of_run = 1'b1;
         unique case (cmd.rsp_sel)
            RSP_PUSH_OK: begin
               occ_val = count_ff + 1'b1;
            end
            RSP_FULL: begin
               rsp_in.status = STATUS_FULL;
            end
            RSP_EMPTY: begin
               rsp_in.status = STATUS_EMPTY;
            end
            RSP_POP: begin
               rsp_in.out_title = rd_data_ff.title;
               rsp_in.out_pages = rd_data_ff.pages;
               occ_val          = count_ff - 1'b1;
            end
            RSP_NOMATCH: begin
               rsp_in.status = STATUS_NOMATCH;
            end
            RSP_MATCH: begin
               rsp_in.out_title   = rd_data_ff.title;
               rsp_in.out_pages   = rd_data_ff.pages;
               rsp_in.last_of_run = (emitted_ff == hits_ff - 1'b1);
               occ_val            = count_ff - hits_ff;
            end
            default: begin
               rsp_in.status = STATUS_OK;
            end
         endcase
         rsp_in.occupancy = OCC_W'(occ_val);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff   <= '0;
         count_ff   <= '0;
         idx_ff     <= '0;
         kept_ff    <= '0;
         hits_ff    <= '0;
         emitted_ff <= '0;
      end else begin
         front_ff   <= front_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         kept_ff    <= kept_in;
         hits_ff    <= hits_in;
         emitted_ff <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign stat.command   = req_ff.command;
   assign stat.full      = (count_ff == CW'(DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.match     = match;
   assign stat.walk_last = (idx_ff == count_ff - 1'b1);
   assign stat.hits_zero = (hits_ff == '0);

   assign rsp_payload = rsp_ff;

endmodule

// File: hw/rtl/rdf_ctrl.sv
// rdf_ctrl: command sequencer and handshake control for the record deque
`timescale 1ns / 1ps

module rdf_ctrl
   import rdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  rdf_stat_type stat,
   output rdf_cmd_type  cmd
);

   rdf_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rsp_sel = RSP_PUSH_OK;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (stat.command)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  cmd.load_rsp = 1'b1;
                  if (stat.full) begin
                     cmd.rsp_sel = RSP_FULL;
                  end else begin
                     cmd.rsp_sel    = RSP_PUSH_OK;
                     cmd.push_front = (stat.command == CMD_PUSH_FRONT);
                     cmd.push_back  = (stat.command == CMD_PUSH_BACK);
                  end
                  state_in = ST_IDLE;
               end
               CMD_POP_FRONT: begin
                  if (stat.empty) begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_sel  = RSP_EMPTY;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.rd_front = 1'b1;
                     state_in     = ST_POP;
                  end
               end
               CMD_FILTER: begin
                  if (stat.empty) begin
                     cmd.load_rsp = 1'b1;
                     cmd.rsp_sel  = RSP_NOMATCH;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_COUNT;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_POP: begin
            cmd.load_rsp   = 1'b1;
            cmd.rsp_sel    = RSP_POP;
            cmd.pop_commit = 1'b1;
            state_in       = ST_IDLE;
         end
         // first pass counts matches so every result carries the final occupancy
         ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (stat.walk_last) begin
               state_in = ST_COUNT_END;
            end
         end
         ST_COUNT_END: begin
            if (stat.hits_zero) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_sel  = RSP_NOMATCH;
               state_in     = ST_IDLE;
            end else begin
               cmd.walk_restart = 1'b1;
               state_in         = ST_EMIT;
            end
         end
         // second pass emits matches and compacts the rest toward the front
         ST_EMIT: begin
            if (!stat.match || out_free) begin
               cmd.emit_step = 1'b1;
               cmd.load_rsp  = stat.match;
               cmd.rsp_sel   = RSP_MATCH;
               if (stat.walk_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            cmd.commit_filter = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/record_deque_with_filter_unit.sv
// record_deque_with_filter_unit: top level of the record deque with page-limit filter
// one transaction in flight: requests are taken only when idle with no stalled result
// the ring memory's single read port sets the walk rate to one record per cycle per pass,
// while the emit pass holds on a match until a stalled result is taken
// reset clears pointers, count, state and result valid; record memory is not cleared
`timescale 1ns / 1ps

module record_deque_with_filter_unit
   import rdf_pkg::*;
#(
   parameter int DEPTH = RDF_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rdf_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rdf_rsp_type rsp_payload
);

   rdf_cmd_type  cmd;
   rdf_stat_type stat;

   rdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rdf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hw/rtl/rdf_checker.sv
// rdf_checker: port-level assertions for the record deque, bound to the top level
`timescale 1ns / 1ps

module rdf_checker
   import rdf_pkg::*;
#(
   parameter int DEPTH = RDF_DEPTH
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input rdf_rsp_type rsp_payload
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // no new transaction while a result is stuck in the output register
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   // error results end the run and carry no record
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != STATUS_OK) |->
         rsp_payload.last_of_run && (rsp_payload.out_title == '0) &&
         (rsp_payload.out_pages == '0))
      else $error("error result with payload or without last flag");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_FULL) |->
         rsp_payload.occupancy == OCC_W'(DEPTH))
      else $error("full status with wrong occupancy");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_EMPTY) |->
         rsp_payload.occupancy == '0)
      else $error("empty status with nonzero occupancy");

endmodule

bind record_deque_with_filter_unit rdf_checker #(
   .DEPTH (DEPTH)
) u_rdf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
